[rtl/core/cpp_pkg.sv]
// ----------------------------------------------------------------------------
// Closed polygon perimeter package
// Shared defaults and the sequencer state type of the perimeter core.
// ----------------------------------------------------------------------------
package cpp_pkg;

  // Default coordinate width (signed Q8.8) and perimeter sum width (Q16.8).
  localparam int unsigned DefCoordBits = 16;
  localparam int unsigned DefSumBits   = 24;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SQX  = 6'b000010,
    ST_SQY  = 6'b000100,
    ST_ADD  = 6'b001000,
    ST_ROOT = 6'b010000,
    ST_EMIT = 6'b100000
  } cpp_state_e;

endpackage

[rtl/core/cpp_isqrt.sv]
// ----------------------------------------------------------------------------
// Iterative integer square root
// Restoring digit-by-digit root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module cpp_isqrt #(
  parameter int unsigned COORD_BITS = cpp_pkg::DefCoordBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [2*COORD_BITS:0] radicand_i,
  output logic [COORD_BITS:0]   root_o,
  output logic                  done_o
);

  localparam int unsigned RootW = COORD_BITS + 1;
  localparam int unsigned RadW  = 2 * COORD_BITS + 2;
  localparam int unsigned RemW  = COORD_BITS + 3;
  localparam int unsigned CntW  = $clog2(COORD_BITS + 1);

  logic [RadW-1:0]  rad_q, rad_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [RemW-1:0]  rem_shift;
  logic [RemW-1:0]  trial;

  // One root digit per cycle: bring down the next bit pair and try 4*root+1.
  assign rem_shift = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial     = {root_q, 2'b01};

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = {1'b0, radicand_i};
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CntW'(COORD_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[RadW-3:0], 2'b00};
      if (rem_shift >= trial) begin
        rem_d  = rem_shift - trial;
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_shift;
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

[rtl/core/closed_polygon_perimeter_core.sv]
// ----------------------------------------------------------------------------
// Closed polygon perimeter core
// Accumulates Euclidean edge lengths of a vertex stream, emits the perimeter.
// ----------------------------------------------------------------------------
// Usage: vertices enter on the slave stream, one word per vertex. tdata holds
// x_coord in the low COORD_BITS and y_coord above it, both signed fixed point;
// tlast marks the final vertex and closes the polygon. The first vertex of a
// polygon is stored. Every further vertex adds the length of the edge from
// the previous vertex: the shared multiplier squares dx and then dy, the
// squares are added, and the iterative root unit takes the root of the sum.
// A vertex with tlast also adds the closing edge back to the first vertex,
// and then the result register is loaded. The block accepts no vertex while
// it works on one. The perimeter leaves on the master stream as one word,
// saturating at its maximum, and all polygon state is cleared. A lone vertex
// with tlast gives zero. If the receiver stalls, the result holds in the
// output register; the next vertex is still taken and processed, and only
// the following result waits until the register is free. Reset clears the
// open polygon and any pending result.
// ----------------------------------------------------------------------------
module closed_polygon_perimeter_core #(
  parameter int unsigned COORD_BITS = cpp_pkg::DefCoordBits,
  parameter int unsigned SUM_BITS   = cpp_pkg::DefSumBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // Fields from bit 0 up: x_coord, y_coord, zero padding to whole bytes.
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  input  logic                              s_axis_tlast_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // Fields from bit 0 up: perimeter_length, zero padding to whole bytes.
  output logic [((SUM_BITS+7)/8)*8-1:0]     m_axis_tdata_o
);

  localparam int unsigned OutW  = ((SUM_BITS + 7) / 8) * 8;
  localparam int unsigned RootW = COORD_BITS + 1;
  localparam int unsigned SqW   = 2 * COORD_BITS;
  localparam int unsigned AccW  = ((SUM_BITS > RootW) ? SUM_BITS : RootW) + 1;

  cpp_pkg::cpp_state_e state_q, state_d;

  // Polygon state.
  logic [COORD_BITS-1:0] first_x_q, first_x_d, first_y_q, first_y_d;
  logic [COORD_BITS-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [SUM_BITS-1:0]   sum_q, sum_d;
  logic                  open_q, open_d;
  logic                  last_q, last_d;
  // Low when the edge in work runs from the previous vertex, high when it is
  // the closing edge back to the first vertex.
  logic                  close_q, close_d;

  // Squaring datapath.
  logic [SqW-1:0]        prod_q, prod_d;
  logic [SqW-1:0]        sqx_q, sqx_d;

  // Result register.
  logic                  m_valid_q, m_valid_d;
  logic [SUM_BITS-1:0]   m_data_q, m_data_d;

  logic                  in_accept;
  logic [COORD_BITS-1:0] in_x, in_y;
  logic [COORD_BITS-1:0] op_a, op_b;
  logic [COORD_BITS:0]   diff;
  logic [COORD_BITS-1:0] mag;
  logic [SqW-1:0]        square;
  logic [2*COORD_BITS:0] radicand;
  logic                  root_start;
  logic [RootW-1:0]      root;
  logic                  root_done;
  logic [AccW-1:0]       acc_sum;
  logic [SUM_BITS-1:0]   sat_sum;

  assign in_x = s_axis_tdata_i[COORD_BITS-1:0];
  assign in_y = s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS];

  assign s_axis_tready_o = (state_q == cpp_pkg::ST_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  // The shared multiplier squares |dx| in ST_SQX and |dy| otherwise.
  always_comb begin
    if (state_q == cpp_pkg::ST_SQX) begin
      op_a = cur_x_q;
      op_b = close_q ? first_x_q : prev_x_q;
    end else begin
      op_a = cur_y_q;
      op_b = close_q ? first_y_q : prev_y_q;
    end
  end

  assign diff   = {op_a[COORD_BITS-1], op_a} - {op_b[COORD_BITS-1], op_b};
  assign mag    = diff[COORD_BITS] ? COORD_BITS'(-diff) : diff[COORD_BITS-1:0];
  assign square = mag * mag;

  assign radicand   = {1'b0, sqx_q} + {1'b0, prod_q};
  assign root_start = (state_q == cpp_pkg::ST_ADD);

  // Saturating accumulation: the sum clips at the all-ones value.
  assign acc_sum = AccW'(sum_q) + AccW'(root);
  assign sat_sum = (acc_sum >= AccW'({SUM_BITS{1'b1}})) ? {SUM_BITS{1'b1}}
                                                        : acc_sum[SUM_BITS-1:0];

  cpp_isqrt #(
    .COORD_BITS(COORD_BITS)
  ) u_isqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (root_start),
    .radicand_i(radicand),
    .root_o    (root),
    .done_o    (root_done)
  );

  always_comb begin
    state_d   = state_q;
    first_x_d = first_x_q;
    first_y_d = first_y_q;
    prev_x_d  = prev_x_q;
    prev_y_d  = prev_y_q;
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    sum_d     = sum_q;
    open_d    = open_q;
    last_d    = last_q;
    close_d   = close_q;
    prod_d    = prod_q;
    sqx_d     = sqx_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      cpp_pkg::ST_IDLE: begin
        if (in_accept) begin
          cur_x_d = in_x;
          cur_y_d = in_y;
          last_d  = s_axis_tlast_i;
          close_d = 1'b0;
          if (!open_q) begin
            // First vertex: nothing to measure yet.
            first_x_d = in_x;
            first_y_d = in_y;
            prev_x_d  = in_x;
            prev_y_d  = in_y;
            sum_d     = '0;
            open_d    = 1'b1;
            if (s_axis_tlast_i) begin
              state_d = cpp_pkg::ST_EMIT;
            end
          end else begin
            state_d = cpp_pkg::ST_SQX;
          end
        end
      end
      cpp_pkg::ST_SQX: begin
        prod_d  = square;
        state_d = cpp_pkg::ST_SQY;
      end
      cpp_pkg::ST_SQY: begin
        sqx_d   = prod_q;
        prod_d  = square;
        state_d = cpp_pkg::ST_ADD;
      end
      cpp_pkg::ST_ADD: begin
        state_d = cpp_pkg::ST_ROOT;
      end
      cpp_pkg::ST_ROOT: begin
        if (root_done) begin
          sum_d = sat_sum;
          if (close_q) begin
            state_d = cpp_pkg::ST_EMIT;
          end else begin
            prev_x_d = cur_x_q;
            prev_y_d = cur_y_q;
            if (last_q) begin
              close_d = 1'b1;
              state_d = cpp_pkg::ST_SQX;
            end else begin
              state_d = cpp_pkg::ST_IDLE;
            end
          end
        end
      end
      cpp_pkg::ST_EMIT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = sum_q;
          sum_d     = '0;
          open_d    = 1'b0;
          state_d   = cpp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cpp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cpp_pkg::ST_IDLE;
      open_q    <= 1'b0;
      sum_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      open_q    <= open_d;
      sum_q     <= sum_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_x_q <= first_x_d;
    first_y_q <= first_y_d;
    prev_x_q  <= prev_x_d;
    prev_y_q  <= prev_y_d;
    cur_x_q   <= cur_x_d;
    cur_y_q   <= cur_y_d;
    last_q    <= last_d;
    close_q   <= close_d;
    prod_q    <= prod_d;
    sqx_q     <= sqx_d;
    m_data_q  <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OutW'(m_data_q);

endmodule

[sim/closed_polygon_perimeter_core_tb.sv]
// ----------------------------------------------------------------------------
// Closed polygon perimeter core testbench
// Streams polygon vertices into the core and keeps its own perimeter
// accumulator, then checks every result word against it in arrival order.
// ----------------------------------------------------------------------------
module closed_polygon_perimeter_core_tb;

  localparam int unsigned CoordBits  = cpp_pkg::DefCoordBits;
  localparam int unsigned SumBits    = cpp_pkg::DefSumBits;
  localparam int unsigned InBits     = ((2*CoordBits+7)/8)*8;
  localparam int unsigned OutBits    = ((SumBits+7)/8)*8;
  localparam longint unsigned SumMax = (64'd1 << SumBits) - 64'd1;
  // A closing vertex measures two sides and then loads the result; allow plenty more.
  localparam int unsigned DrainCycles = 4*(CoordBits+5) + 20;
  localparam int unsigned CycleLimit  = 400000;

  // Coordinate styles for random polygons.
  localparam int StyleWide   = 0;
  localparam int StyleNear   = 1;
  localparam int StyleCorner = 2;

  localparam logic [CoordBits-1:0] CoordMin = {1'b1, {(CoordBits-1){1'b0}}};
  localparam logic [CoordBits-1:0] CoordMax = {1'b0, {(CoordBits-1){1'b1}}};
  localparam logic [CoordBits-1:0] CoordOne = CoordBits'(256);

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid_i;
  logic               s_axis_tready_o;
  logic [InBits-1:0]  s_axis_tdata_i;
  logic               s_axis_tlast_i;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i;
  logic [OutBits-1:0] m_axis_tdata_o;

  // Shadow of the polygon being built.
  logic [CoordBits-1:0] first_x, first_y, prev_x, prev_y;
  logic [SumBits-1:0]   run_sum;
  logic                 poly_open;

  logic [SumBits-1:0] perimeter_q[$];
  logic [OutBits-1:0] expected_word;

  int unsigned mismatches   = 0;
  int unsigned vertices_in  = 0;
  int unsigned cycle_count  = 0;
  int unsigned stall_left   = 0;
  bit          no_idle      = 1'b0;

  closed_polygon_perimeter_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Digit-by-digit floor square root over the full 64-bit range.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned rem, root, trial;
    rem  = 0;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      rem   = (rem << 2) | ((v >> (2*i)) & 64'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // Length of one side, taken on the raw fixed-point codes.
  function automatic longint unsigned side_length(logic [CoordBits-1:0] ax, ay, bx, by);
    longint dx, dy;
    dx = $signed(ax) - $signed(bx);
    dy = $signed(ay) - $signed(by);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return int_sqrt(longint'(dx*dx + dy*dy));
  endfunction

  function automatic logic [SumBits-1:0] sat_sum(logic [SumBits-1:0] a, longint unsigned b);
    longint unsigned t;
    t = longint'(a) + b;
    return (b >= SumMax || t > SumMax) ? SumBits'(SumMax) : SumBits'(t);
  endfunction

  task automatic clear_polygon();
    first_x   = '0;
    first_y   = '0;
    prev_x    = '0;
    prev_y    = '0;
    run_sum   = '0;
    poly_open = 1'b0;
  endtask

  // Advance the shadow accumulator by one accepted vertex.
  task automatic track_vertex(logic [CoordBits-1:0] x, y, logic closing);
    if (!poly_open) begin
      first_x   = x;
      first_y   = y;
      run_sum   = '0;
      poly_open = 1'b1;
    end else begin
      run_sum = sat_sum(run_sum, side_length(prev_x, prev_y, x, y));
    end
    prev_x = x;
    prev_y = y;
    if (closing) begin
      run_sum = sat_sum(run_sum, side_length(x, y, first_x, first_y));
      perimeter_q.push_back(run_sum);
      clear_polygon();
    end
  endtask

  task automatic report_mismatch(string what, logic [OutBits-1:0] want, got);
    $display("MISMATCH %s: expected %0d, got %0d (after %0d vertices)",
             what, want, got, vertices_in);
    mismatches++;
  endtask

  // Send one vertex word, now and then with a random gap in front of it, and
  // wait for it to be taken.
  task automatic send_vertex(logic [CoordBits-1:0] x, y, logic closing);
    int gap;
    @(negedge clk_i);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i = '0;
    s_axis_tdata_i[CoordBits-1:0]           = x;
    s_axis_tdata_i[2*CoordBits-1:CoordBits] = y;
    s_axis_tlast_i  = closing;
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    track_vertex(x, y, closing);
    vertices_in++;
  endtask

  // Stop sending and hold until every expected perimeter has come out.
  task automatic wait_drain();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (perimeter_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [CoordBits-1:0] pick_coord(int style, logic [CoordBits-1:0] center);
    case (style)
      StyleNear: begin
        return center + CoordBits'($urandom_range(0, 511)) - CoordBits'(256);
      end
      StyleCorner: begin
        case ($urandom_range(0, 3))
          0:       return CoordMin;
          1:       return CoordMax;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: begin
        return CoordBits'($urandom);
      end
    endcase
  endfunction

  // Extremes, lone vertices, zero-length sides and a known right triangle.
  task automatic test_directed();
    send_vertex('0, '0, 1'b1);
    send_vertex(CoordMax, CoordMin, 1'b1);
    // Opposite corners: the longest possible side, taken twice.
    send_vertex(CoordMin, CoordMin, 1'b0);
    send_vertex(CoordMax, CoordMax, 1'b1);
    // A 3-4-5 triangle gives exactly 12.0.
    send_vertex('0, '0, 1'b0);
    send_vertex(CoordBits'(3) * CoordOne, '0, 1'b0);
    send_vertex(CoordBits'(3) * CoordOne, CoordBits'(4) * CoordOne, 1'b1);
    // The same point three times.
    send_vertex(CoordOne, CoordOne, 1'b0);
    send_vertex(CoordOne, CoordOne, 1'b0);
    send_vertex(CoordOne, CoordOne, 1'b1);
    // Square around the origin with a repeated corner.
    send_vertex(-CoordOne, -CoordOne, 1'b0);
    send_vertex(CoordOne, -CoordOne, 1'b0);
    send_vertex(CoordOne, CoordOne, 1'b0);
    send_vertex(CoordOne, CoordOne, 1'b0);
    send_vertex(-CoordOne, CoordOne, 1'b1);
    // Full-span horizontal and vertical sides.
    send_vertex(CoordMin, '0, 1'b0);
    send_vertex(CoordMax, '0, 1'b1);
    send_vertex('0, CoordMax, 1'b0);
    send_vertex('0, CoordMin, 1'b1);
    send_vertex('1, '1, 1'b1);
  endtask

  // Bounce between opposite corners until the sum pins at its maximum, then
  // check that the next polygon starts from zero.
  task automatic test_saturation();
    for (int i = 0; i < 190; i++) begin
      if (i % 2 == 0) send_vertex(CoordMin, CoordMin, 1'b0);
      else            send_vertex(CoordMax, CoordMax, 1'b0);
    end
    send_vertex(CoordMax, CoordMin, 1'b1);
    send_vertex('0, '0, 1'b0);
    send_vertex(CoordOne, '0, 1'b1);
  endtask

  // Hold the sender back until the core and the output side are empty.
  task automatic test_drain_pause();
    for (int p = 0; p < 3; p++) begin
      for (int i = 0; i < p + 2; i++) begin
        send_vertex(CoordBits'($urandom), CoordBits'($urandom), i == p + 1);
      end
      wait_drain();
    end
  endtask

  // Random polygons: mostly short, some lone vertices, a few long ones.
  task automatic test_random(int unsigned count);
    int unsigned target, sides, roll;
    int style;
    logic [CoordBits-1:0] cx, cy, x, y;
    target = vertices_in + count;
    while (vertices_in < target) begin
      roll = $urandom_range(0, 19);
      if (roll == 0)      sides = 1;
      else if (roll == 1) sides = $urandom_range(30, 60);
      else                sides = $urandom_range(2, 10);
      style = $urandom_range(0, 2);
      cx = CoordBits'($urandom);
      cy = CoordBits'($urandom);
      x  = pick_coord(style, cx);
      y  = pick_coord(style, cy);
      for (int unsigned i = 0; i < sides; i++) begin
        // Now and then a vertex repeats the one before it.
        if (i == 0 || $urandom_range(0, 7) != 0) begin
          x = pick_coord(style, cx);
          y = pick_coord(style, cy);
        end
        send_vertex(x, y, i == sides - 1);
      end
    end
  endtask

  // Last stretch runs at full rate on both sides.
  task automatic test_full_rate(int unsigned count);
    no_idle = 1'b1;
    test_random(count);
  endtask

  // Receiver: random stall bursts, none in the final stretch.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready_i = 1'b0;
    end else if (!no_idle && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      m_axis_tready_i = 1'b0;
    end else begin
      m_axis_tready_i = 1'b1;
    end
  end

  // Each result word taken is checked against the oldest expected perimeter.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (perimeter_q.size() == 0) begin
        report_mismatch("perimeter with none pending", '0, m_axis_tdata_o);
      end else begin
        expected_word = '0;
        expected_word[SumBits-1:0] = perimeter_q.pop_front();
        if (m_axis_tdata_o !== expected_word) begin
          report_mismatch("perimeter_length", expected_word, m_axis_tdata_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("closed_polygon_perimeter_core test failed");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    clear_polygon();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_saturation();
    test_drain_pause();
    test_random(720);
    test_full_rate(100);

    wait_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("closed_polygon_perimeter_core test passed");
    end else begin
      $display("closed_polygon_perimeter_core test failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/cpp_pkg.sv
rtl/core/cpp_isqrt.sv
rtl/core/closed_polygon_perimeter_core.sv
sim/closed_polygon_perimeter_core_tb.sv
